FILE: design/subx_pkg.sv
// Shared types, codes and constants for the subtract-with-extend execute unit.
package subx_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned FLAG_W     = 5;
    localparam int unsigned S_TDATA_W  = 120;
    localparam int unsigned M_TDATA_W  = 136;

    // Flag bit positions within the condition code word
    localparam int unsigned FLAG_X = 4;
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_V = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [2:0] STACK_PTR = 3'd7;

    typedef enum logic [1:0] {
        CMD_EXEC       = 2'd0,
        CMD_LOAD_REG   = 2'd1,
        CMD_READ_REG   = 2'd2,
        CMD_LOAD_FLAGS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2,
        SIZE_NONE = 2'd3
    } size_t;

    typedef struct packed {
        cmd_t              command;
        logic [15:0]       opcode;
        logic [3:0]        reg_index;
        logic [XLEN-1:0]   load_value;
        logic [XLEN-1:0]   src_operand;
        logic [XLEN-1:0]   dst_operand;
    } item_t;

    typedef struct packed {
        logic              executed;
        logic              mem_write;
        logic [XLEN-1:0]   mem_address;
        logic [XLEN-1:0]   src_address;
        logic [XLEN-1:0]   mem_data;
        logic [XLEN-1:0]   reg_data;
        logic [FLAG_W-1:0] flags_out;
    } result_t;

    // Register file read ports
    typedef struct packed {
        logic [XLEN-1:0]   d_rx;
        logic [XLEN-1:0]   d_ry;
        logic [XLEN-1:0]   a_rx;
        logic [XLEN-1:0]   a_ry;
        logic [XLEN-1:0]   r_idx;
        logic [FLAG_W-1:0] flags;
    } reg_rd_t;

    // Register file write requests; a1 is applied after a0
    typedef struct packed {
        logic              d_we;
        logic [2:0]        d_addr;
        logic [XLEN-1:0]   d_data;
        logic              a0_we;
        logic [2:0]        a0_addr;
        logic [XLEN-1:0]   a0_data;
        logic              a1_we;
        logic [2:0]        a1_addr;
        logic [XLEN-1:0]   a1_data;
        logic              f_we;
        logic [FLAG_W-1:0] f_data;
    } reg_wr_t;

endpackage

FILE: design/subx_regfile.sv
// Data registers, address registers and condition flags with their read and write ports.
module subx_regfile
    import subx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [2:0] rx,
    input  logic [2:0] ry,
    input  logic [3:0] idx,
    input  reg_wr_t    wr,
    output reg_rd_t    rd
);

    logic [XLEN-1:0]   data_reg  [8];
    logic [XLEN-1:0]   addr_reg  [8];
    logic [FLAG_W-1:0] flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                data_reg[i] <= '0;
                addr_reg[i] <= '0;
            end
            flags_reg <= '0;
        end else begin
            if (wr.d_we) begin
                data_reg[wr.d_addr] <= wr.d_data;
            end
            if (wr.a0_we) begin
                addr_reg[wr.a0_addr] <= wr.a0_data;
            end
            // second write wins when both hit the same register
            if (wr.a1_we) begin
                addr_reg[wr.a1_addr] <= wr.a1_data;
            end
            if (wr.f_we) begin
                flags_reg <= wr.f_data;
            end
        end
    end

    always_comb begin
        rd.d_rx  = data_reg[rx];
        rd.d_ry  = data_reg[ry];
        rd.a_rx  = addr_reg[rx];
        rd.a_ry  = addr_reg[ry];
        rd.r_idx = idx[3] ? addr_reg[idx[2:0]] : data_reg[idx[2:0]];
        rd.flags = flags_reg;
    end

endmodule

FILE: design/subx_exec.sv
// Decode of one command word: subtraction with extend, flag update and register writes.
module subx_exec
    import subx_pkg::*;
(
    input  item_t   item,
    input  reg_rd_t rd,
    output result_t res,
    output reg_wr_t wr
);

    size_t             size;
    logic [2:0]        rx;
    logic [2:0]        ry;
    logic              mem_form;
    logic [XLEN-1:0]   mask;
    logic [2:0]        step;
    logic [2:0]        sstep;
    logic [2:0]        dstep;
    logic [XLEN-1:0]   src_addr;
    logic [XLEN-1:0]   dst_base;
    logic [XLEN-1:0]   dst_addr;
    logic [XLEN-1:0]   s;
    logic [XLEN-1:0]   d;
    logic [XLEN-1:0]   r;
    logic [XLEN-1:0]   new_d;
    logic              sm;
    logic              dm;
    logic              rm;
    logic              c;
    logic              v;
    logic              z;
    logic [FLAG_W-1:0] new_flags;

    always_comb begin
        size     = size_t'(item.opcode[7:6]);
        rx       = item.opcode[11:9];
        ry       = item.opcode[2:0];
        mem_form = item.opcode[3];

        unique case (size)
            SIZE_BYTE: begin
                mask = 32'h0000_00ff;
                step = 3'd1;
            end
            SIZE_WORD: begin
                mask = 32'h0000_ffff;
                step = 3'd2;
            end
            SIZE_LONG: begin
                mask = 32'hffff_ffff;
                step = 3'd4;
            end
            SIZE_NONE: begin
                mask = 32'hffff_ffff;
                step = 3'd4;
            end
        endcase

        // keep A7 word aligned on byte steps
        sstep = (size == SIZE_BYTE && ry == STACK_PTR) ? 3'd2 : step;
        dstep = (size == SIZE_BYTE && rx == STACK_PTR) ? 3'd2 : step;

        src_addr = rd.a_ry - {29'd0, sstep};
        dst_base = (rx == ry) ? src_addr : rd.a_rx;
        dst_addr = dst_base - {29'd0, dstep};

        s = (mem_form ? item.src_operand : rd.d_ry) & mask;
        d = (mem_form ? item.dst_operand : rd.d_rx) & mask;
        r = (d - s - {31'd0, rd.flags[FLAG_X]}) & mask;

        new_d = (rd.d_rx & ~mask) | r;

        unique case (size)
            SIZE_BYTE: begin
                sm = s[7];
                dm = d[7];
                rm = r[7];
            end
            SIZE_WORD: begin
                sm = s[15];
                dm = d[15];
                rm = r[15];
            end
            SIZE_LONG: begin
                sm = s[31];
                dm = d[31];
                rm = r[31];
            end
            SIZE_NONE: begin
                sm = s[31];
                dm = d[31];
                rm = r[31];
            end
        endcase

        c = (sm & ~dm) | (rm & ~dm) | (sm & rm);
        v = (~sm & dm & ~rm) | (sm & ~dm & rm);
        // Z only ever clears
        z = rd.flags[FLAG_Z] & (r == '0);

        new_flags         = '0;
        new_flags[FLAG_X] = c;
        new_flags[FLAG_N] = rm;
        new_flags[FLAG_Z] = z;
        new_flags[FLAG_V] = v;
        new_flags[FLAG_C] = c;

        res           = '0;
        res.flags_out = rd.flags;
        wr            = '0;

        unique case (item.command)
            CMD_EXEC: begin
                if (size != SIZE_NONE) begin
                    res.executed  = 1'b1;
                    res.flags_out = new_flags;
                    wr.f_we       = 1'b1;
                    wr.f_data     = new_flags;
                    if (mem_form) begin
                        res.mem_write   = 1'b1;
                        res.mem_address = dst_addr;
                        res.src_address = src_addr;
                        res.mem_data    = r;
                        res.reg_data    = dst_addr;
                        wr.a0_we        = 1'b1;
                        wr.a0_addr      = ry;
                        wr.a0_data      = src_addr;
                        wr.a1_we        = 1'b1;
                        wr.a1_addr      = rx;
                        wr.a1_data      = dst_addr;
                    end else begin
                        res.reg_data = new_d;
                        wr.d_we      = 1'b1;
                        wr.d_addr    = rx;
                        wr.d_data    = new_d;
                    end
                end
            end
            CMD_LOAD_REG: begin
                res.reg_data = item.load_value;
                if (item.reg_index[3]) begin
                    wr.a1_we   = 1'b1;
                    wr.a1_addr = item.reg_index[2:0];
                    wr.a1_data = item.load_value;
                end else begin
                    wr.d_we   = 1'b1;
                    wr.d_addr = item.reg_index[2:0];
                    wr.d_data = item.load_value;
                end
            end
            CMD_READ_REG: begin
                res.reg_data = rd.r_idx;
            end
            CMD_LOAD_FLAGS: begin
                wr.f_we       = 1'b1;
                wr.f_data     = item.load_value[FLAG_W-1:0];
                res.flags_out = item.load_value[FLAG_W-1:0];
            end
        endcase
    end

endmodule

FILE: design/subtract_extended_execute.sv
// Subtract-with-extend execute unit: stream ports, input and result registers.
//
// Usage: each word on the s_ channel is one command (execute a SUBX opcode,
// load a register, read a register or load the flags), selected by s_tuser.
// Every accepted word yields exactly one result word on the m_ channel,
// carrying addresses, memory write data, register data and the flags.
// Pipeline: two register stages (input register, result register).
// Throughput: one word per cycle while m_tready is high; the register file
// and flags are read and updated in the same cycle that a word moves from
// the input register to the result register, so the next word sees the
// updated state.
// Reset (aresetn low, synchronous): both stages empty, all data and address
// registers and the flags cleared.
// Stall: while m_tready is low the result is held; the input register still
// takes one more word, after which s_tready drops until the result drains.
module subtract_extended_execute
    import subx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[15:0], reg_index[19:16], load_value[51:20],
    // src_operand[83:52], dst_operand[115:84], zero pad[119:116]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // mem_address[31:0], src_address[63:32], mem_data[95:64],
    // reg_data[127:96], flags_out[132:128], zero pad[135:133]
    output logic [M_TDATA_W-1:0] m_tdata,
    // executed[0], mem_write[1]
    output logic [1:0]           m_tuser
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    logic    advance;
    reg_rd_t rd;
    reg_wr_t wr;
    reg_wr_t wr_gated;
    result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_item_next.command     = cmd_t'(s_tuser);
        in_item_next.opcode      = s_tdata[15:0];
        in_item_next.reg_index   = s_tdata[19:16];
        in_item_next.load_value  = s_tdata[51:20];
        in_item_next.src_operand = s_tdata[83:52];
        in_item_next.dst_operand = s_tdata[115:84];

        priority if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        priority if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    subx_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rx      (in_item_reg.opcode[11:9]),
        .ry      (in_item_reg.opcode[2:0]),
        .idx     (in_item_reg.reg_index),
        .wr      (wr_gated),
        .rd      (rd)
    );

    subx_exec u_exec (
        .item (in_item_reg),
        .rd   (rd),
        .res  (res),
        .wr   (wr)
    );

    // commit state only when the word actually moves on
    always_comb begin
        wr_gated       = wr;
        wr_gated.d_we  = wr.d_we  && advance;
        wr_gated.a0_we = wr.a0_we && advance;
        wr_gated.a1_we = wr.a1_we && advance;
        wr_gated.f_we  = wr.f_we  && advance;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.flags_out, out_res_reg.reg_data,
                       out_res_reg.mem_data, out_res_reg.src_address,
                       out_res_reg.mem_address};
    assign m_tuser  = {out_res_reg.mem_write, out_res_reg.executed};

`ifndef NO_ASSERTIONS
    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but s_tready low");

    a_write_implies_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("memory write reported without execution");

    a_z_only_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.command == CMD_EXEC && !rd.flags[FLAG_Z]
        |=> !rd.flags[FLAG_Z])
        else $error("Z set by a subtraction");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && m_tready && !in_valid_reg |=> !out_valid_reg)
        else $error("result word repeated after being taken");
`endif

endmodule
